// ===== design/pmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmst_pkg;

	// Operation codes carried in the input tuser field.
	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_ADD     = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;

	// Fixed field widths of the stream payloads and the configuration word.
	localparam int VTX_BITS   = 4;
	localparam int WIDTH_FIELD = 16;
	localparam int CNT_BITS   = 5;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CLEAR  = 7'b0000010,
		ST_WR2    = 7'b0000100,
		ST_LOAD   = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_SEARCH = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic init;
		logic shift;
		logic update;
		logic take;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/pmst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/pmst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmst_cell import pmst_pkg::*; #(
	parameter int IDX = 0,
	parameter int WB  = 16,
	parameter int VW  = 4,
	parameter int NW  = 5
) (
	input  wire logic            clk,
	input  wire cell_ctl_t       ctl,
	input  wire logic [VW-1:0]   pick,
	input  wire logic [NW-1:0]   n_active,
	input  wire logic [WB-1:0]   w_in,
	output logic      [WB-1:0]   w_out,
	input  wire logic [WB:0]     tok_low_in,
	input  wire logic [VW-1:0]   tok_idx_in,
	input  wire logic            tok_fnd_in,
	output logic      [WB:0]     tok_low_out,
	output logic      [VW-1:0]   tok_idx_out,
	output logic                 tok_fnd_out,
	output logic      [WB:0]     key,
	output logic      [VW-1:0]   parent,
	output logic                 in_tree
);

	localparam logic [WB:0] KEY_NONE = {1'b1, {WB{1'b0}}};

	logic [WB-1:0] w_q;
	logic [WB:0]   key_q;
	logic [VW-1:0] par_q;
	logic          tree_q;
	logic          active;
	logic          better;
	logic          relax;

	assign active = NW'(IDX) < n_active;
	assign better = active && !tree_q && (key_q < tok_low_in);
	assign relax  = active && !tree_q && (w_q != '0) && ({1'b0, w_q} < key_q);

	// Matrix row shifts through the chain one cell per cycle while shift is asserted.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			w_q <= w_in;
		end
	end

	// Key, parent and tree membership of this vertex.
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			key_q  <= (IDX == 0) ? '0 : KEY_NONE;
			par_q  <= '0;
			tree_q <= 1'b0;
		end else begin
			if (ctl.update && relax) begin
				key_q <= {1'b0, w_q};
				par_q <= pick;
			end
			if (ctl.take && (pick == VW'(IDX))) begin
				tree_q <= 1'b1;
			end
		end
	end

	// The running minimum passes to the next cell each cycle.
	always_ff @(posedge clk) begin
		tok_low_out <= better ? key_q : tok_low_in;
		tok_idx_out <= better ? VW'(IDX) : tok_idx_in;
		tok_fnd_out <= better | tok_fnd_in;
	end

	assign w_out   = w_q;
	assign key     = key_q;
	assign parent  = par_q;
	assign in_tree = tree_q;

endmodule

`default_nettype wire

// ===== design/prim_minimum_spanning_tree_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An edge load writes the weight at (a,b) and then at (b,a); a clear sweeps the whole
// matrix memory. A compute runs a minimum search through the cell chain, then, for each
// vertex taken into the tree, a row shift through the chain, a key update and a new
// search; the results then leave through the output register. One item is processed at a
// time; the input is ready only when the sequencer is idle. After reset the block runs a
// clearing pass before it accepts items; vertex_count resets to 16.

module prim_minimum_spanning_tree_core import pmst_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CNT_BITS-1:0] cfg_wdata,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [23:0]         s_tdata,   // vertex_a, vertex_b, edge_weight
	input  wire logic [1:0]          s_tuser,   // func
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [23:0]         m_tdata,   // parent_vertex, child_vertex, tree_weight
	output logic                     m_tuser,   // reached
	output logic                     m_tlast
);

	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VW;
	localparam int WB = WEIGHT_BITS;
	localparam logic [WB:0] KEY_NONE = {1'b1, {WB{1'b0}}};

	state_t        state_q;
	logic [CNT_BITS-1:0] vcount_q;
	logic [AW-1:0] clr_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] pick_q;
	logic [VW-1:0] emit_q;
	logic [AW-1:0] addr2_q;
	logic [WB-1:0] wgt2_q;
	logic          rd_vld_q;

	logic [NW-1:0] n_active;
	logic          in_acc;
	logic [1:0]    func;
	logic [VW-1:0] va;
	logic [VW-1:0] vb;
	logic          ends_ok;
	logic [WB-1:0] wgt_in;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [WB-1:0] ram_rdata;

	cell_ctl_t     ctl;
	logic [VW-1:0] pick_bc;
	logic [WB-1:0] w_chain  [MAX_VERTICES+1];
	logic [WB:0]   tok_low  [MAX_VERTICES+1];
	logic [VW-1:0] tok_idx  [MAX_VERTICES+1];
	logic          tok_fnd  [MAX_VERTICES+1];
	logic [WB:0]   key_a    [MAX_VERTICES];
	logic [VW-1:0] par_a    [MAX_VERTICES];
	logic          tree_a   [MAX_VERTICES];

	logic          out_ld;
	logic          emit_last;

	// Vertex count in use, held within 2 and MAX_VERTICES.
	always_comb begin
		if (vcount_q < 5'd2) begin
			n_active = NW'(2);
		end else if (32'(vcount_q) > 32'(MAX_VERTICES)) begin
			n_active = NW'(MAX_VERTICES);
		end else begin
			n_active = NW'(vcount_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign func     = s_tuser;
	assign va       = VW'(s_tdata[3:0]);
	assign vb       = VW'(s_tdata[7:4]);
	assign wgt_in   = WB'(s_tdata[23:8]);
	assign ends_ok  = (32'(s_tdata[3:0]) < 32'(MAX_VERTICES)) &&
			(32'(s_tdata[7:4]) < 32'(MAX_VERTICES));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	// Matrix memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = addr2_q;
				ram_wdata = wgt2_q;
			end
			ST_IDLE: begin
				ram_we    = in_acc && (func == FUNC_ADD) && ends_ok;
				ram_waddr = {va, vb};
				ram_wdata = wgt_in;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = {pick_q, VW'(MAX_VERTICES - 1) - cnt_q[VW-1:0]};

	pmst_ram #(
		.WIDTH(WB),
		.DEPTH(1 << AW)
	) u_matrix (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Broadcast control to the cells.
	assign ctl.init   = in_acc && (func == FUNC_COMPUTE);
	assign ctl.shift  = rd_vld_q;
	assign ctl.update = (state_q == ST_UPDATE);
	assign ctl.take   = (state_q == ST_SEARCH) && (cnt_q == NW'(MAX_VERTICES)) &&
			tok_fnd[MAX_VERTICES];
	assign pick_bc    = ctl.take ? tok_idx[MAX_VERTICES] : pick_q;

	assign w_chain[0] = ram_rdata;
	assign tok_low[0] = KEY_NONE;
	assign tok_idx[0] = '0;
	assign tok_fnd[0] = 1'b0;

	// Chain of vertex cells.
	for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_cell
		pmst_cell #(
			.IDX(v),
			.WB (WB),
			.VW (VW),
			.NW (NW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.pick       (pick_bc),
			.n_active   (n_active),
			.w_in       (w_chain[v]),
			.w_out      (w_chain[v+1]),
			.tok_low_in (tok_low[v]),
			.tok_idx_in (tok_idx[v]),
			.tok_fnd_in (tok_fnd[v]),
			.tok_low_out(tok_low[v+1]),
			.tok_idx_out(tok_idx[v+1]),
			.tok_fnd_out(tok_fnd[v+1]),
			.key        (key_a[v]),
			.parent     (par_a[v]),
			.in_tree    (tree_a[v])
		);
	end

	assign emit_last = (NW'(emit_q) == n_active - NW'(1));
	assign out_ld    = (state_q == ST_EMIT) && (!m_tvalid || m_tready);

	// Sequencer: clear sweep, edge writes, Prim rounds and result emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			cnt_q    <= '0;
			pick_q   <= '0;
			emit_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_LOAD) && (cnt_q < NW'(MAX_VERTICES));
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (func == FUNC_CLEAR) begin
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (func == FUNC_ADD && ends_ok) begin
							state_q <= ST_WR2;
						end else if (func == FUNC_COMPUTE) begin
							cnt_q   <= '0;
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WR2: begin
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(MAX_VERTICES)) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cnt_q   <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (cnt_q == NW'(MAX_VERTICES)) begin
						cnt_q <= '0;
						if (tok_fnd[MAX_VERTICES]) begin
							pick_q  <= tok_idx[MAX_VERTICES];
							state_q <= ST_LOAD;
						end else begin
							emit_q  <= VW'(1);
							state_q <= ST_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_EMIT: begin
					if (out_ld) begin
						emit_q <= emit_q + VW'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Second half of a symmetric edge write.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr2_q <= {vb, va};
			wgt2_q  <= wgt_in;
		end
	end

	// Output register holds one result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ld) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			m_tdata[3:0]  <= tree_a[emit_q] ? VTX_BITS'(par_a[emit_q]) : '0;
			m_tdata[7:4]  <= VTX_BITS'(emit_q);
			m_tdata[23:8] <= tree_a[emit_q] ? WIDTH_FIELD'(key_a[emit_q][WB-1:0]) : '0;
			m_tuser       <= tree_a[emit_q];
			m_tlast       <= emit_last;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/prim_minimum_spanning_tree_core_test.sv =====
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_core_test;
	import pmst_pkg::*;

	localparam int NV = 16;
	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [3:0]  parent;
		logic [3:0]  child;
		logic [15:0] weight;
		logic        reached;
		logic        last;
	} tree_edge_t;

	typedef struct {
		logic [1:0]  func;
		logic [3:0]  va;
		logic [3:0]  vb;
		logic [15:0] w;
		logic        cfg;       // write vertex_count before this row
		logic [4:0]  cnt;
		int          n_typed;   // number of typed expectations, 0 = use predictor
		tree_edge_t  typed [3];
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	// Shadow state of the graph and register.
	logic [15:0] adj [NV][NV];
	logic [4:0] vcount;
	tree_edge_t tree_q[$];

	int cycle_cnt = 0;
	int mismatches = 0;
	bit quiet = 1'b0;

	always #1 clk = ~clk;

	prim_minimum_spanning_tree_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Prim's algorithm on the shadow matrix; pushes an expectation per active vertex except vertex 0.
	task automatic predict_tree();
		int n;
		logic [16:0] key [NV];
		logic [3:0] par [NV];
		bit done [NV];
		logic [16:0] low;
		int pick;
		bit found;
		tree_edge_t e;
		n = (vcount < 2) ? 2 : ((vcount > NV) ? NV : int'(vcount));
		for (int v = 0; v < NV; v++) begin
			key[v] = 17'h10000;
			par[v] = '0;
			done[v] = 1'b0;
		end
		key[0] = '0;
		for (int i = 0; i < n; i++) begin
			low = 17'h10000;
			pick = 0;
			found = 1'b0;
			for (int v = 0; v < n; v++) begin
				if (!done[v] && key[v] < low) begin
					low = key[v];
					pick = v;
					found = 1'b1;
				end
			end
			if (!found) break;
			done[pick] = 1'b1;
			for (int v = 0; v < n; v++) begin
				if (adj[pick][v] != 0 && !done[v] && {1'b0, adj[pick][v]} < key[v]) begin
					key[v] = {1'b0, adj[pick][v]};
					par[v] = 4'(pick);
				end
			end
		end
		for (int v = 1; v < n; v++) begin
			e.reached = done[v];
			e.parent = done[v] ? par[v] : 4'd0;
			e.child = 4'(v);
			e.weight = done[v] ? key[v][15:0] : 16'd0;
			e.last = (v == n - 1);
			tree_q.push_back(e);
		end
	endtask

	// Applies one accepted operation to the shadow state.
	task automatic apply_op(input logic [1:0] f, input logic [3:0] a, input logic [3:0] b,
			input logic [15:0] w);
		case (f)
			FUNC_CLEAR: begin
				foreach (adj[i, j]) adj[i][j] = '0;
			end
			FUNC_ADD: begin
				adj[a][b] = w;
				adj[b][a] = w;
			end
			FUNC_COMPUTE: begin
				predict_tree();
			end
			default: ;
		endcase
	endtask

	// Sends one transaction with a random lead-in gap; tvalid is dropped only in a gap.
	task automatic send_item(input logic [1:0] f, input logic [3:0] a, input logic [3:0] b,
			input logic [15:0] w);
		while (!quiet && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {w, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits until all expected results have arrived, then lets the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tree_q.size() != 0) @(negedge clk);
		repeat (2 * NV * NV + 100) @(negedge clk);
	endtask

	task automatic write_count(input logic [4:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		vcount = c;
	endtask

	// Receiver stall pattern.
	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		tree_edge_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[7:4], m_tdata[23:8], m_tuser, m_tlast};
			if (tree_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = tree_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected p=%0d c=%0d w=%0d r=%0b l=%0b, ",
							want.parent, want.child, want.weight, want.reached,
							want.last, "got p=%0d c=%0d w=%0d r=%0b l=%0b",
							got.parent, got.child, got.weight, got.reached, got.last);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	stim_row_t rows[$];

	function automatic stim_row_t mk(input logic [1:0] f, input int a, input int b, input int w);
		stim_row_t r;
		r.func = f;
		r.va = 4'(a);
		r.vb = 4'(b);
		r.w = 16'(w);
		r.cfg = 1'b0;
		r.cnt = '0;
		r.n_typed = 0;
		return r;
	endfunction

	initial begin
		stim_row_t r;
		int nv;
		logic [4:0] counts [6] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd9};
		foreach (adj[i, j]) adj[i][j] = '0;
		vcount = 5'd16;

		// Directed table; typed rows hold fixed expectations in place of the predictor's.
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.cfg = 1'b1;
		r.cnt = 5'd2;
		r.n_typed = 1;
		r.typed[0] = '{4'd0, 4'd1, 16'd0, 1'b0, 1'b1};
		rows.push_back(r);
		rows.push_back(mk(FUNC_ADD, 0, 1, 16'hFFFF));
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.n_typed = 1;
		r.typed[0] = '{4'd0, 4'd1, 16'hFFFF, 1'b1, 1'b1};
		rows.push_back(r);
		rows.push_back(mk(FUNC_ADD, 1, 1, 7));
		rows.push_back(mk(FUNC_ADD, 15, 15, 3));
		rows.push_back(mk(FUNC_ADD, 1, 0, 1));
		rows.push_back(mk(FUNC_UNUSED, 0, 1, 99));
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.n_typed = 1;
		r.typed[0] = '{4'd0, 4'd1, 16'd1, 1'b1, 1'b1};
		rows.push_back(r);
		rows.push_back(mk(FUNC_ADD, 0, 2, 5));
		rows.push_back(mk(FUNC_ADD, 1, 2, 5));
		rows.push_back(mk(FUNC_ADD, 2, 14, 4));
		rows.push_back(mk(FUNC_ADD, 0, 15, 2));
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.cfg = 1'b1;
		r.cnt = 5'd16;
		rows.push_back(r);
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.cfg = 1'b1;
		r.cnt = 5'd31;
		rows.push_back(r);
		rows.push_back(mk(FUNC_ADD, 0, 1, 0));
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.cfg = 1'b1;
		r.cnt = 5'd3;
		rows.push_back(r);
		rows.push_back(mk(FUNC_CLEAR, 0, 0, 0));
		r = mk(FUNC_COMPUTE, 0, 0, 0);
		r.cfg = 1'b1;
		r.cnt = 5'd0;
		r.n_typed = 1;
		r.typed[0] = '{4'd0, 4'd1, 16'd0, 1'b0, 1'b1};
		rows.push_back(r);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[k]) begin
			if (rows[k].cfg) write_count(rows[k].cnt);
			send_item(rows[k].func, rows[k].va, rows[k].vb, rows[k].w);
			if (rows[k].n_typed != 0)
				for (int t = 0; t < rows[k].n_typed; t++) tree_q.push_back(rows[k].typed[t]);
			else
				apply_op(rows[k].func, rows[k].va, rows[k].vb, rows[k].w);
			if (rows[k].func == FUNC_ADD) begin
				adj[rows[k].va][rows[k].vb] = rows[k].w;
				adj[rows[k].vb][rows[k].va] = rows[k].w;
			end
		end

		// Random phases: mostly edge loads then a compute, over several counts.
		for (int ph = 0; ph < 24; ph++) begin
			logic [1:0] f;
			logic [3:0] a, b;
			logic [15:0] w;
			write_count(ph < 6 ? counts[ph] : 5'($urandom_range(31)));
			quiet = (ph == 10 || ph == 11);
			nv = (vcount < 2) ? 2 : ((vcount > NV) ? NV : int'(vcount));
			if ($urandom_range(3) == 0) begin
				send_item(FUNC_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
				apply_op(FUNC_CLEAR, 0, 0, 0);
			end
			for (int e = 0; e < 12; e++) begin
				case ($urandom_range(9))
					0: f = FUNC_UNUSED;
					1: f = FUNC_CLEAR;
					default: f = FUNC_ADD;
				endcase
				if ($urandom_range(4) == 0) begin
					a = 4'($urandom);
					b = 4'($urandom);
				end else begin
					a = 4'($urandom_range(nv - 1));
					b = 4'($urandom_range(nv - 1));
				end
				case ($urandom_range(3))
					0: w = 16'($urandom);
					1: w = 16'($urandom_range(0, 1)) | 16'h8000;
					default: w = 16'($urandom_range(0, 8));
				endcase
				send_item(f, a, b, w);
				apply_op(f, a, b, w);
			end
			send_item(FUNC_COMPUTE, 4'($urandom), 4'($urandom), 16'($urandom));
			apply_op(FUNC_COMPUTE, 0, 0, 0);
			quiet = 1'b0;
		end

		drain();
		if (mismatches == 0 && tree_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
